/* sv/tccw_pkg.sv */
// shared types and constants of the text console cell writer
package tccw_pkg;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int ADDR_IN_W = 11;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;

    // character codes and reset attribute
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation codes on the input channel
    typedef enum logic [OP_W-1:0] {
        OP_PUT       = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    // classified command kinds
    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_BACKSPACE,
        CMD_CLEAR,
        CMD_READ,
        CMD_READ_NONE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [CHAR_W-1:0]      char_code;
        logic [ADDR_IN_W-1:0]   cell_address;
    } t_cmd;

    typedef struct packed {
        logic [CELL_W-1:0]      cell_data;
        logic [COL_OUT_W-1:0]   cursor_col;
        logic [ROW_OUT_W-1:0]   cursor_row;
        logic                   scrolled;
    } t_result;

    // back-end sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCR_RD,
        S_SCR_WR,
        S_BLANK,
        S_DONE
    } t_state;

endpackage

/* sv/text_console_cell_writer.sv */
// top level of the text console cell writer
//
// channel   direction  handshake                      payload
// input     in         i_in_valid / o_in_stall        i_op, i_char_code, i_cell_address
// result    out        o_out_valid / i_out_stall      o_cell_data, o_cursor_col,
//                                                     o_cursor_row, o_scrolled
// config    in         i_cfg_valid / o_cfg_ready      i_cfg_data (text attribute)
//
// put, newline, backspace and out-of-range read: answered from the idle state unless a scroll is needed
// read: answered from S_READ (registered store read)
// scroll: one store port read then write per moved cell, then the bottom row is blanked
// clear: one blank cell written per cycle over the whole store
// after reset the store is zeroed with o_in_stall high
// o_in_stall also rises when the two-entry command queue is full
module text_console_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tccw_pkg::OP_W-1:0]      i_op,
    input  logic [tccw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tccw_pkg::ADDR_IN_W-1:0] i_cell_address,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tccw_pkg::CELL_W-1:0]    o_cell_data,
    output logic [tccw_pkg::COL_OUT_W-1:0] o_cursor_col,
    output logic [tccw_pkg::ROW_OUT_W-1:0] o_cursor_row,
    output logic                           o_scrolled,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tccw_pkg::ATTR_W-1:0]    i_cfg_data
);
    import tccw_pkg::*;

    logic              cfg_write;
    logic [ATTR_W-1:0] r_text_attribute;
    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_valid;
    logic              init_busy;
    t_cmd              front_cmd;
    t_cmd              queue_cmd;
    t_result           result;

    // attribute register, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attribute <= ATTR_RESET;
        end else if (cfg_write) begin
            r_text_attribute <= i_cfg_data;
        end
    end

    // front end
    tccw_front #(
        .CELL_COUNT (COLUMNS * ROWS)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_char_code    (i_char_code),
        .i_cell_address (i_cell_address),
        .i_queue_full   (queue_full),
        .i_init_busy    (init_busy),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    // command queue
    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // back end
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_text_attribute),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_cell_data  = result.cell_data;
    assign o_cursor_col = result.cursor_col;
    assign o_cursor_row = result.cursor_row;
    assign o_scrolled   = result.scrolled;

endmodule

/* sv/tccw_front.sv */
// front end: input handshake and command classification
module tccw_front #(
    parameter int CELL_COUNT = 2000
) (
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tccw_pkg::OP_W-1:0]     i_op,
    input  logic [tccw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tccw_pkg::ADDR_IN_W-1:0] i_cell_address,
    input  logic                          i_queue_full,
    input  logic                          i_init_busy,
    output logic                          o_push,
    output tccw_pkg::t_cmd                o_cmd
);
    import tccw_pkg::*;

    t_op op;

    assign op = t_op'(i_op);

    // hold off while the queue is full or the screen store is being zeroed after reset
    assign o_in_stall = i_queue_full | i_init_busy;
    assign o_push     = i_in_valid & ~o_in_stall;

    // classify the transaction into a command
    always_comb begin
        o_cmd.char_code    = i_char_code;
        o_cmd.cell_address = i_cell_address;
        unique case (op)
            OP_PUT: begin
                o_cmd.kind = (i_char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
            end
            OP_BACKSPACE: begin
                o_cmd.kind = CMD_BACKSPACE;
            end
            OP_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
            end
            OP_READ: begin
                o_cmd.kind = (int'(i_cell_address) < CELL_COUNT) ? CMD_READ : CMD_READ_NONE;
            end
            default: begin
                o_cmd.kind = CMD_READ_NONE;
            end
        endcase
    end

endmodule

/* sv/tccw_queue.sv */
// short command queue between front and back
module tccw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tccw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tccw_pkg::t_cmd o_cmd
);
    import tccw_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* sv/tccw_back.sv */
// back end: screen store, cursor and command sequencer
module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tccw_pkg::ATTR_W-1:0] i_attr,
    input  logic                        i_cmd_valid,
    input  tccw_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_init_busy,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tccw_pkg::t_result           o_result
);
    import tccw_pkg::*;

    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int AW          = $clog2(CELL_COUNT);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int ROW_W       = $clog2(ROWS);
    localparam logic [AW-1:0]    LAST_CELL   = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0]    SCROLL_LAST = AW'(CELL_COUNT - COLUMNS - 1);
    localparam logic [COL_W-1:0] LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_scr, n_scr;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              out_free;
    logic              start;
    logic              need_scroll;
    logic [AW-1:0]     cur_pos;
    logic [CELL_W-1:0] blank_cell;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;

    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign start       = (r_state == S_IDLE) & i_cmd_valid & out_free;
    assign cur_pos     = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign blank_cell  = {i_attr, SPACE_CODE};
    assign o_init_busy = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // a line feed or a wrapping put on the bottom row needs a scroll
    always_comb begin
        need_scroll = 1'b0;
        if (r_row == LAST_ROW) begin
            if (i_cmd.kind == CMD_NEWLINE) begin
                need_scroll = 1'b1;
            end else if (i_cmd.kind == CMD_PUT && r_col == LAST_COL) begin
                need_scroll = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_ptr == LAST_CELL) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    priority case (i_cmd.kind)
                        CMD_PUT, CMD_NEWLINE: n_state = need_scroll ? S_SCR_RD : S_IDLE;
                        CMD_CLEAR:            n_state = S_BLANK;
                        CMD_READ:             n_state = S_READ;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (out_free) n_state = S_IDLE;
            end
            S_SCR_RD: begin
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                if (r_ptr == SCROLL_LAST) n_state = S_BLANK;
                else n_state = S_SCR_RD;
            end
            S_BLANK: begin
                if (r_ptr == LAST_CELL) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath controls and result
    always_comb begin
        n_ptr       = r_ptr;
        n_col       = r_col;
        n_row       = r_row;
        n_scr       = r_scr;
        mem_we      = 1'b0;
        mem_wa      = r_ptr;
        mem_wd      = blank_cell;
        mem_re      = 1'b0;
        mem_ra      = r_ptr + AW'(COLUMNS);
        o_cmd_pop   = 1'b0;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wd = '0;
                n_ptr  = r_ptr + 1'b1;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd_pop = 1'b1;
                    priority case (i_cmd.kind)
                        CMD_PUT, CMD_NEWLINE: begin
                            if (i_cmd.kind == CMD_PUT) begin
                                mem_we = 1'b1;
                                mem_wa = cur_pos;
                                mem_wd = {i_attr, i_cmd.char_code};
                            end
                            if (i_cmd.kind == CMD_NEWLINE || r_col == LAST_COL) begin
                                n_col = '0;
                                n_row = (r_row == LAST_ROW) ? LAST_ROW : r_row + 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                            n_ptr = '0;
                            n_scr = need_scroll;
                        end
                        CMD_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col  = r_col - 1'b1;
                                mem_we = 1'b1;
                                mem_wa = cur_pos - 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_col = '0;
                            n_row = '0;
                            n_ptr = '0;
                            n_scr = 1'b0;
                        end
                        CMD_READ: begin
                            mem_re = 1'b1;
                            mem_ra = AW'(i_cmd.cell_address);
                        end
                        default: begin
                        end
                    endcase
                    // single-step commands answer at once
                    if (!(i_cmd.kind == CMD_CLEAR || i_cmd.kind == CMD_READ || need_scroll)) begin
                        n_out_valid      = 1'b1;
                        n_out.cell_data  = '0;
                        n_out.cursor_col = COL_OUT_W'(n_col);
                        n_out.cursor_row = ROW_OUT_W'(n_row);
                        n_out.scrolled   = 1'b0;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.cell_data  = r_rd_data;
                    n_out.cursor_col = COL_OUT_W'(r_col);
                    n_out.cursor_row = ROW_OUT_W'(r_row);
                    n_out.scrolled   = 1'b0;
                end
            end
            S_SCR_RD: begin
                mem_re = 1'b1;
            end
            S_SCR_WR: begin
                mem_we = 1'b1;
                mem_wd = r_rd_data;
                n_ptr  = r_ptr + 1'b1;
            end
            S_BLANK: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.cell_data  = '0;
                    n_out.cursor_col = COL_OUT_W'(r_col);
                    n_out.cursor_row = ROW_OUT_W'(r_row);
                    n_out.scrolled   = r_scr;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_scr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_scr       <= n_scr;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // screen store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // cursor never leaves the screen
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= LAST_ROW) && (r_col <= LAST_COL))
        else $error("cursor outside screen");

    // writes stay inside the store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_wa <= LAST_CELL))
        else $error("screen write out of range");

    // no result while the reset clearing pass runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_out_valid)
        else $error("result during clearing pass");

    // a scrolled result leaves the cursor on the last row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.scrolled) |-> (r_out.cursor_row == ROW_OUT_W'(ROWS - 1)))
        else $error("scroll left cursor off last row");

    // a command is only taken when the result register can hold its answer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE) && i_cmd_valid && out_free)
        else $error("command taken while busy");

endmodule

/* tb/tb.sv */
// testbench of the text console cell writer: predicted screen and cursor checked per result
`timescale 1ns / 1ps

module tb;
    import tccw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int LIMIT   = 10_000_000;
    localparam int BATCHES = 6;
    localparam int BATCH_ITEMS = 48;

    typedef struct {
        t_op                  op;
        logic [CHAR_W-1:0]    ch;
        logic [ADDR_IN_W-1:0] addr;
    } t_console_cmd;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op = '0;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic [ADDR_IN_W-1:0] i_cell_address = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CELL_W-1:0]    o_cell_data;
    logic [COL_OUT_W-1:0] o_cursor_col;
    logic [ROW_OUT_W-1:0] o_cursor_row;
    logic                 o_scrolled;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [ATTR_W-1:0]    i_cfg_data = '0;

    // console model state
    logic [CELL_W-1:0] screen_model [CELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] text_attr;

    // stimulus and expectations
    t_console_cmd   console_cmds [$];
    t_result        predicted_status [$];
    t_console_cmd   on_wire;
    bit             cmd_in_flight;
    int             send_idle_pct;
    int             recv_idle_pct;

    // run statistics
    int error_count;
    int results_checked;
    int scroll_count;
    int wrap_count;
    int read_count;
    int offscreen_reads;
    int clear_count;
    int attr_writes;
    longint cycle_count;

    text_console_cell_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_char_code   (i_char_code),
        .i_cell_address(i_cell_address),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_data   (o_cell_data),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_row  (o_cursor_row),
        .o_scrolled    (o_scrolled),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // apply one operation to the screen model and return the status it produces
    function automatic t_result apply_console_op(t_console_cmd c);
        t_result r;
        int      pos;
        r = '0;
        case (c.op)
            OP_PUT: begin
                if (c.ch == NEWLINE_CODE) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    pos = cur_row * COLUMNS + cur_col;
                    if (pos < CELLS) screen_model[pos] = {text_attr, c.ch};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                        wrap_count++;
                    end
                end
                // scroll up one row and blank the bottom row
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_model[i] = {text_attr, SPACE_CODE};
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                    scroll_count++;
                end
            end
            OP_BACKSPACE: begin
                if (cur_col > 0) begin
                    cur_col--;
                    screen_model[cur_row * COLUMNS + cur_col] = {text_attr, SPACE_CODE};
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen_model[i] = {text_attr, SPACE_CODE};
                cur_col = 0;
                cur_row = 0;
                clear_count++;
            end
            default: begin
                read_count++;
                if (c.addr < CELLS) r.cell_data = screen_model[c.addr];
                else offscreen_reads++;
            end
        endcase
        r.cursor_col = COL_OUT_W'(cur_col);
        r.cursor_row = ROW_OUT_W'(cur_row);
        return r;
    endfunction

    // driver: presents queued commands, predicts each accepted transaction
    always @(posedge i_clk) begin
        logic busy;
        busy = i_in_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_status.push_back(apply_console_op(on_wire));
                cmd_in_flight = 1'b0;
                busy = 1'b0;
            end
            if (!busy) begin
                if (console_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_wire = console_cmds.pop_front();
                    cmd_in_flight = 1'b1;
                    i_in_valid <= 1'b1;
                    i_op <= on_wire.op;
                    i_char_code <= on_wire.ch;
                    i_cell_address <= on_wire.addr;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (predicted_status.size() == 0) begin
                    error_count++;
                    $display({"%0t: unexpected result, expected none",
                              " actual data %h col %0d row %0d scr %b"},
                             $time, o_cell_data, o_cursor_col, o_cursor_row, o_scrolled);
                end else begin
                    want = predicted_status.pop_front();
                    if (o_cell_data !== want.cell_data) begin
                        error_count++;
                        $display("%0t: cell_data mismatch, expected %h actual %h",
                                 $time, want.cell_data, o_cell_data);
                    end
                    if (o_cursor_col !== want.cursor_col) begin
                        error_count++;
                        $display("%0t: cursor_col mismatch, expected %0d actual %0d",
                                 $time, want.cursor_col, o_cursor_col);
                    end
                    if (o_cursor_row !== want.cursor_row) begin
                        error_count++;
                        $display("%0t: cursor_row mismatch, expected %0d actual %0d",
                                 $time, want.cursor_row, o_cursor_row);
                    end
                    if (o_scrolled !== want.scrolled) begin
                        error_count++;
                        $display("%0t: scrolled mismatch, expected %b actual %b",
                                 $time, want.scrolled, o_scrolled);
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, predicted_status.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic queue_cmd(t_op op, logic [CHAR_W-1:0] ch, logic [ADDR_IN_W-1:0] addr);
        t_console_cmd c;
        c.op = op;
        c.ch = ch;
        c.addr = addr;
        console_cmds.push_back(c);
    endtask

    // wait until every queued command has been answered
    task automatic wait_drained();
        while (console_cmds.size() > 0 || cmd_in_flight || predicted_status.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        text_attr = value;
        attr_writes++;
    endtask

    // random command sequences: text lines, newline runs, reads, backspaces, clears, noise
    task automatic queue_random_batch(int n);
        int                   added;
        int                   kind;
        int                   len;
        int                   pick;
        logic [CHAR_W-1:0]    ch;
        logic [ADDR_IN_W-1:0] addr;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                pick = $urandom_range(99);
                if (pick < 55) len = $urandom_range(12, 1);
                else if (pick < 80) len = $urandom_range(83, 77);
                else len = $urandom_range(76, 13);
                for (int i = 0; i < len; i++) begin
                    do ch = CHAR_W'($urandom_range(255)); while (ch == NEWLINE_CODE);
                    queue_cmd(OP_PUT, ch, ADDR_IN_W'($urandom_range(2047)));
                end
                added += len;
                if ($urandom_range(99) < 60) begin
                    queue_cmd(OP_PUT, NEWLINE_CODE, ADDR_IN_W'($urandom_range(2047)));
                    added++;
                end
            end else if (kind < 50) begin
                len = $urandom_range(30, 1);
                for (int i = 0; i < len; i++)
                    queue_cmd(OP_PUT, NEWLINE_CODE, ADDR_IN_W'($urandom_range(2047)));
                added += len;
            end else if (kind < 78) begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(99);
                    if (pick < 40) addr = ADDR_IN_W'($urandom_range(CELLS - 1, CELLS - 400));
                    else if (pick < 70) addr = ADDR_IN_W'($urandom_range(399));
                    else if (pick < 90) addr = ADDR_IN_W'($urandom_range(2047));
                    else addr = ADDR_IN_W'($urandom_range(2047, CELLS));
                    queue_cmd(OP_READ, CHAR_W'($urandom_range(255)), addr);
                end
                added += len;
            end else if (kind < 90) begin
                len = $urandom_range(5, 1);
                for (int i = 0; i < len; i++)
                    queue_cmd(OP_BACKSPACE, CHAR_W'($urandom_range(255)),
                              ADDR_IN_W'($urandom_range(2047)));
                added += len;
            end else if (kind < 93) begin
                queue_cmd(OP_CLEAR, CHAR_W'($urandom_range(255)),
                          ADDR_IN_W'($urandom_range(2047)));
                added++;
            end else begin
                queue_cmd(t_op'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                          ADDR_IN_W'($urandom_range(2047)));
                added++;
            end
        end
    endtask

    // main sequence
    initial begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
        cur_col = 0;
        cur_row = 0;
        text_attr = ATTR_RESET;
        cmd_in_flight = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 48;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset contents, edges of the address range, backspace, newline, clear
        queue_cmd(OP_READ, 8'h00, 11'd0);
        queue_cmd(OP_READ, 8'hFF, 11'd1999);
        queue_cmd(OP_READ, 8'h00, 11'd2000);
        queue_cmd(OP_READ, 8'h00, 11'd2047);
        queue_cmd(OP_BACKSPACE, 8'h00, 11'd0);
        queue_cmd(OP_PUT, 8'h41, 11'd0);
        queue_cmd(OP_PUT, 8'hFF, 11'd2047);
        queue_cmd(OP_PUT, 8'h00, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd1);
        queue_cmd(OP_READ, 8'h00, 11'd2);
        queue_cmd(OP_BACKSPACE, 8'hFF, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd2);
        queue_cmd(OP_PUT, NEWLINE_CODE, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd3);
        queue_cmd(OP_BACKSPACE, 8'h00, 11'd0);
        queue_cmd(OP_PUT, 8'h7E, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd80);
        queue_cmd(OP_CLEAR, 8'h00, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd0);
        queue_cmd(OP_READ, 8'h00, 11'd1999);
        queue_cmd(OP_PUT, 8'h80, 11'd1024);
        queue_cmd(OP_READ, 8'h00, 11'd0);
        wait_drained();

        // random batches, each after an attribute change and a full drain
        for (int b = 0; b < BATCHES; b++) begin
            if (b < 2) begin
                send_idle_pct = 27;
                recv_idle_pct = 48;
            end else if (b < 4) begin
                send_idle_pct = 48;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (b == 0) write_attribute(8'h00);
            else if (b == 1) write_attribute(8'hFF);
            else write_attribute(ATTR_W'($urandom_range(255)));
            queue_random_batch(BATCH_ITEMS);
            wait_drained();
        end
        repeat (20) @(posedge i_clk);

        $display("checked %0d results: %0d scrolls, %0d line wraps, %0d clears",
                 results_checked, scroll_count, wrap_count, clear_count);
        $display("%0d reads (%0d off screen), %0d attribute writes, %0d cycles",
                 read_count, offscreen_reads, attr_writes, cycle_count);
        if (error_count == 0 && predicted_status.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
sv/tccw_pkg.sv
sv/tccw_front.sv
sv/tccw_queue.sv
sv/tccw_back.sv
sv/text_console_cell_writer.sv
tb/tb.sv
